/* hdl/dmxr_pkg.sv */
`timescale 1ns / 1ps
package dmxr_pkg;

	localparam int W_OP   = 3;
	localparam int W_BYTE = 8;
	localparam int W_CHAN = 10;
	localparam int W_TOUT = 16;
	localparam int W_PH   = 2;
	localparam int W_REG  = 2;
	localparam int W_CFG  = 16;

	typedef logic [W_OP-1:0]   op_t;
	typedef logic [W_BYTE-1:0] byte_t;
	typedef logic [W_CHAN-1:0] chan_t;
	typedef logic [W_TOUT-1:0] tout_t;
	typedef logic [W_PH-1:0]   phase_t;
	typedef logic [W_REG-1:0]  reg_idx_t;
	typedef logic [W_CFG-1:0]  cfg_data_t;

	localparam op_t OP_BYTE   = 3'd0;
	localparam op_t OP_BREAK  = 3'd1;
	localparam op_t OP_TICK   = 3'd2;
	localparam op_t OP_COMMIT = 3'd3;
	localparam op_t OP_READ   = 3'd4;

	localparam phase_t PH_IDLE  = 2'd0;
	localparam phase_t PH_AWAIT = 2'd1;
	localparam phase_t PH_DATA  = 2'd2;

	localparam reg_idx_t REG_START_CODE = 2'd0;
	localparam reg_idx_t REG_TIMEOUT    = 2'd1;
	localparam reg_idx_t REG_READY_CNT  = 2'd2;

	localparam byte_t START_CODE_RST = 8'd0;
	localparam tout_t TIMEOUT_RST    = 16'd1000;
	localparam chan_t READY_CNT_RST  = 10'd2;

	typedef struct packed {
		op_t   opcode;
		byte_t data_byte;
		chan_t channel_number;
	} req_t;

	typedef struct packed {
		byte_t  read_value;
		phase_t receiver_state;
		chan_t  channels_received;
		logic   frame_pending;
		logic   timed_out;
	} rsp_t;

	typedef struct packed {
		logic run;
		logic last;
	} swp_stat_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ZERO,
		ST_COPY,
		ST_EMIT
	} state_t;

endpackage

/* hdl/dmxr_ifs.sv */
`timescale 1ns / 1ps
interface dmxr_req_if;
	logic           valid;
	logic           ready;
	dmxr_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dmxr_rsp_if;
	logic           valid;
	logic           ready;
	dmxr_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/dmx512_frame_receiver.sv */
`timescale 1ns / 1ps
// DMX512 frame receiver.
// req carries one word per operation: received byte, break, millisecond tick,
// commit or channel read. rsp returns exactly one status word per request,
// in order: read value, receiver phase, channel count, pending and timeout.
// Registers (start code, timeout, ready count) are to be written by the user
// through cfg_we/cfg_index/cfg_data while no request is in flight; the block
// itself does not enforce this. Most requests go from ST_IDLE via ST_EMIT to
// the rsp output register. A matching start code (fill buffer clear) and a
// commit with a pending frame (fill to active copy) go through ST_ZERO or
// ST_COPY before ST_EMIT, driven by one address sweep counter that walks the
// buffer RAMs one entry per cycle. A new request is taken only once the last
// request's word is in the output register; req.ready is low while a request
// is being worked. Reset: control state and registers take their reset
// values, then a sweep in ST_CLEAR zeroes both buffers with req.ready low.
// A stalled rsp holds its word in the output register; the next request is
// still taken and its word waits until that register frees up.
module dmx512_frame_receiver #(
	parameter int CHANNELS   = 512,
	parameter int TIMER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dmxr_req_if.sink             req,
	dmxr_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  dmxr_pkg::reg_idx_t   cfg_index,
	input  dmxr_pkg::cfg_data_t  cfg_data
);

	localparam int AW   = $clog2(CHANNELS);
	localparam int CNTW = $clog2(CHANNELS + 1);
	localparam int CMPW = (CNTW > dmxr_pkg::W_CHAN) ? CNTW : dmxr_pkg::W_CHAN;
	localparam int TCW  = (TIMER_BITS > dmxr_pkg::W_TOUT) ? TIMER_BITS : dmxr_pkg::W_TOUT;

	dmxr_pkg::state_t    state_q, state_d;
	dmxr_pkg::phase_t    phase_q;
	logic [CNTW-1:0]     cnt_q;
	logic                pend_q;
	logic [TIMER_BITS-1:0] timer_q;
	dmxr_pkg::byte_t     start_code_q;
	dmxr_pkg::tout_t     timeout_q;
	dmxr_pkg::chan_t     ready_cnt_q;
	logic                rd_ok_q;
	logic                tout_q;
	logic                copy_s1;
	logic [AW-1:0]       caddr_s1;
	logic                out_valid_q;
	dmxr_pkg::rsp_t      out_q;

	dmxr_pkg::op_t       op;
	dmxr_pkg::byte_t     byte_in;
	dmxr_pkg::chan_t     ch_in;
	logic                acc;
	logic                is_start;
	logic                has_room;
	logic                ch_ok;
	logic                timeout_hit;
	logic [CMPW-1:0]     cnt_next;

	logic                fill_we, fill_re, act_we, act_re;
	logic [AW-1:0]       fill_waddr, fill_raddr, act_waddr, act_raddr;
	dmxr_pkg::byte_t     fill_wdata, fill_rdata, act_wdata, act_rdata;
	logic                swp_start;
	logic [AW-1:0]       swp_addr;
	dmxr_pkg::swp_stat_t swp;
	logic                emit;

	assign op       = req.data.opcode;
	assign byte_in  = req.data.data_byte;
	assign ch_in    = req.data.channel_number;
	assign acc      = req.valid && req.ready;
	assign is_start = (phase_q == dmxr_pkg::PH_AWAIT) && (byte_in == start_code_q);
	assign has_room = cnt_q < CNTW'(CHANNELS);
	assign ch_ok    = (ch_in != '0) && (CMPW'(ch_in) <= CMPW'(CHANNELS));
	assign timeout_hit = TCW'(timer_q) > TCW'(timeout_q);
	assign cnt_next = CMPW'(cnt_q) + 1'b1;

	dmxr_sweep #(.DEPTH(CHANNELS)) u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (swp_start),
		.addr   (swp_addr),
		.stat   (swp)
	);

	dmxr_ram #(.WIDTH(dmxr_pkg::W_BYTE), .DEPTH(CHANNELS)) u_fill (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (fill_re),
		.raddr (fill_raddr),
		.rdata (fill_rdata)
	);

	dmxr_ram #(.WIDTH(dmxr_pkg::W_BYTE), .DEPTH(CHANNELS)) u_active (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_waddr),
		.wdata (act_wdata),
		.re    (act_re),
		.raddr (act_raddr),
		.rdata (act_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dmxr_pkg::ST_CLEAR: begin
				if (swp.last) state_d = dmxr_pkg::ST_IDLE;
			end
			dmxr_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (op == dmxr_pkg::OP_BYTE && is_start) begin
						state_d = dmxr_pkg::ST_ZERO;
					end else if (op == dmxr_pkg::OP_COMMIT && pend_q) begin
						state_d = dmxr_pkg::ST_COPY;
					end else begin
						state_d = dmxr_pkg::ST_EMIT;
					end
				end
			end
			dmxr_pkg::ST_ZERO, dmxr_pkg::ST_COPY: begin
				if (swp.last) state_d = dmxr_pkg::ST_EMIT;
			end
			dmxr_pkg::ST_EMIT: begin
				if (!out_valid_q || rsp.ready) state_d = dmxr_pkg::ST_IDLE;
			end
			default: state_d = dmxr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready  = 1'b0;
		fill_we    = 1'b0;
		fill_waddr = swp_addr;
		fill_wdata = '0;
		fill_re    = 1'b0;
		fill_raddr = swp_addr;
		act_we     = 1'b0;
		act_waddr  = swp_addr;
		act_wdata  = '0;
		act_re     = 1'b0;
		act_raddr  = AW'(ch_in - 1'b1);
		swp_start  = 1'b0;
		emit       = 1'b0;
		case (state_q)
			dmxr_pkg::ST_CLEAR: begin
				fill_we = 1'b1;
				act_we  = 1'b1;
			end
			dmxr_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (op)
						dmxr_pkg::OP_BYTE: begin
							if (is_start) begin
								swp_start = 1'b1;
							end else if (phase_q == dmxr_pkg::PH_DATA && has_room) begin
								fill_we    = 1'b1;
								fill_waddr = cnt_q[AW-1:0];
								fill_wdata = byte_in;
							end
						end
						dmxr_pkg::OP_COMMIT: swp_start = pend_q;
						dmxr_pkg::OP_READ:   act_re = ch_ok;
						default: ;
					endcase
				end
			end
			dmxr_pkg::ST_ZERO: fill_we = 1'b1;
			dmxr_pkg::ST_COPY: fill_re = 1'b1;
			dmxr_pkg::ST_EMIT: emit = !out_valid_q || rsp.ready;
			default: ;
		endcase
		// last copy write drains in the first emit cycle
		if (copy_s1) begin
			act_we    = 1'b1;
			act_waddr = caddr_s1;
			act_wdata = fill_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmxr_pkg::ST_CLEAR;
			copy_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			copy_s1 <= (state_q == dmxr_pkg::ST_COPY);
		end
	end

	always_ff @(posedge clk) begin
		caddr_s1 <= swp_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= dmxr_pkg::START_CODE_RST;
			timeout_q    <= dmxr_pkg::TIMEOUT_RST;
			ready_cnt_q  <= dmxr_pkg::READY_CNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dmxr_pkg::REG_START_CODE: start_code_q <= cfg_data[dmxr_pkg::W_BYTE-1:0];
				dmxr_pkg::REG_TIMEOUT:    timeout_q    <= cfg_data[dmxr_pkg::W_TOUT-1:0];
				dmxr_pkg::REG_READY_CNT:  ready_cnt_q  <= cfg_data[dmxr_pkg::W_CHAN-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dmxr_pkg::PH_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			timer_q <= '0;
			rd_ok_q <= 1'b0;
			tout_q  <= 1'b0;
		end else if (acc) begin
			rd_ok_q <= 1'b0;
			tout_q  <= 1'b0;
			case (op)
				dmxr_pkg::OP_BYTE: begin
					if (phase_q == dmxr_pkg::PH_AWAIT) begin
						phase_q <= is_start ? dmxr_pkg::PH_DATA : dmxr_pkg::PH_IDLE;
						cnt_q   <= '0;
					end else if (phase_q == dmxr_pkg::PH_DATA) begin
						if (has_room) begin
							cnt_q <= cnt_q + 1'b1;
							if (cnt_next >= CMPW'(ready_cnt_q)) pend_q <= 1'b1;
						end else begin
							pend_q  <= 1'b1;
							phase_q <= dmxr_pkg::PH_IDLE;
							cnt_q   <= '0;
						end
					end else begin
						phase_q <= dmxr_pkg::PH_IDLE;
						cnt_q   <= '0;
					end
				end
				dmxr_pkg::OP_BREAK: begin
					phase_q <= dmxr_pkg::PH_AWAIT;
					timer_q <= '0;
				end
				dmxr_pkg::OP_TICK: begin
					if (timer_q != '1) timer_q <= timer_q + 1'b1;
				end
				dmxr_pkg::OP_COMMIT: begin
					if (timeout_hit) begin
						tout_q  <= 1'b1;
						phase_q <= dmxr_pkg::PH_IDLE;
						cnt_q   <= '0;
					end
					pend_q <= 1'b0;
				end
				dmxr_pkg::OP_READ: rd_ok_q <= ch_ok;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.read_value        <= rd_ok_q ? act_rdata : '0;
			out_q.receiver_state    <= phase_q;
			out_q.channels_received <= dmxr_pkg::chan_t'(cnt_q);
			out_q.frame_pending     <= pend_q;
			out_q.timed_out         <= tout_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	a_sweep_state: assert property (@(posedge clk) disable iff (!arst_n)
		swp.run == (state_q == dmxr_pkg::ST_CLEAR || state_q == dmxr_pkg::ST_ZERO
			|| state_q == dmxr_pkg::ST_COPY))
		else $error("sweep unit and sequencer disagree");

	a_commit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == dmxr_pkg::OP_COMMIT) |=> !pend_q)
		else $error("pending flag survived commit");

	a_timer_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == dmxr_pkg::OP_TICK && timer_q == '1) |=> (timer_q == '1))
		else $error("break timer wrapped");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(CHANNELS))
		else $error("channel counter out of range");

endmodule

/* hdl/dmxr_ram.sv */
`timescale 1ns / 1ps
module dmxr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/dmxr_sweep.sv */
`timescale 1ns / 1ps
module dmxr_sweep #(
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic [$clog2(DEPTH)-1:0] addr,
	output dmxr_pkg::swp_stat_t      stat
);

	localparam int AW = $clog2(DEPTH);

	logic [AW-1:0] idx_q;
	logic          busy_q;
	logic          last;

	assign last      = busy_q && (idx_q == AW'(DEPTH - 1));
	assign addr      = idx_q;
	assign stat.run  = busy_q;
	assign stat.last = last;

	// a clearing pass runs straight out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

/* dv/dmx512_frame_receiver_checker.sv */
`timescale 1ns / 1ps
module dmx512_frame_receiver_checker #(
	parameter int CHANNELS   = 512,
	parameter int TIMER_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	dmxr_req_if                 req,
	dmxr_rsp_if                 rsp,
	input  logic                cfg_we,
	input  dmxr_pkg::reg_idx_t  cfg_index,
	input  dmxr_pkg::cfg_data_t cfg_data,
	output int                  fail_count,
	output int                  outstanding
);
	import dmxr_pkg::*;

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

	byte_t                 start_code;
	tout_t                 timeout_ticks;
	chan_t                 ready_count;
	phase_t                rx_phase;
	int unsigned           chan_count;
	logic                  frame_pend;
	logic [TIMER_BITS-1:0] break_timer;
	byte_t                 fill_buf [CHANNELS];
	byte_t                 active_buf [CHANNELS];
	rsp_t                  status_queue [$];

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic rsp_t status_after(req_t w);
		rsp_t s;
		s.read_value = '0;
		s.timed_out  = 1'b0;
		case (w.opcode)
			OP_BYTE: begin
				if (rx_phase == PH_AWAIT) begin
					chan_count = 0;
					if (w.data_byte == start_code) begin
						rx_phase = PH_DATA;
						foreach (fill_buf[i]) fill_buf[i] = '0;
					end else begin
						rx_phase = PH_IDLE;
					end
				end else if (rx_phase == PH_DATA) begin
					if (chan_count < CHANNELS) begin
						fill_buf[chan_count] = w.data_byte;
						chan_count++;
						if (chan_count >= ready_count) frame_pend = 1'b1;
					end else begin
						frame_pend = 1'b1;
						rx_phase   = PH_IDLE;
						chan_count = 0;
					end
				end else if (rx_phase != PH_IDLE) begin
					rx_phase   = PH_IDLE;
					chan_count = 0;
				end
			end
			OP_BREAK: begin
				rx_phase    = PH_AWAIT;
				break_timer = '0;
			end
			OP_TICK: begin
				if (break_timer != TIMER_MAX) break_timer++;
			end
			OP_COMMIT: begin
				if (break_timer > timeout_ticks) begin
					s.timed_out = 1'b1;
					rx_phase    = PH_IDLE;
					chan_count  = 0;
				end
				if (frame_pend) begin
					active_buf = fill_buf;
					frame_pend = 1'b0;
				end
			end
			OP_READ: begin
				if (w.channel_number >= 1 && w.channel_number <= CHANNELS)
					s.read_value = active_buf[w.channel_number - 1];
			end
			default: ;
		endcase
		s.receiver_state    = rx_phase;
		s.channels_received = chan_t'(chan_count);
		s.frame_pending     = frame_pend;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			start_code    = START_CODE_RST;
			timeout_ticks = TIMEOUT_RST;
			ready_count   = READY_CNT_RST;
			rx_phase      = PH_IDLE;
			chan_count    = 0;
			frame_pend    = 1'b0;
			break_timer   = '0;
			foreach (fill_buf[i]) fill_buf[i] = '0;
			foreach (active_buf[i]) active_buf[i] = '0;
			status_queue.delete();
			fail_count    = 0;
			outstanding   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_START_CODE: start_code    = cfg_data[W_BYTE-1:0];
					REG_TIMEOUT:    timeout_ticks = cfg_data[W_TOUT-1:0];
					REG_READY_CNT:  ready_count   = cfg_data[W_CHAN-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (status_queue.size() == 0) begin
					$error("status word with no request waiting");
					fail_count++;
				end else begin
					want = status_queue.pop_front();
					got  = rsp.data;
					check_field("read_value", want.read_value, got.read_value);
					check_field("receiver_state", want.receiver_state, got.receiver_state);
					check_field("channels_received", want.channels_received,
						got.channels_received);
					check_field("frame_pending", want.frame_pending, got.frame_pending);
					check_field("timed_out", want.timed_out, got.timed_out);
				end
			end
			if (req.valid && req.ready) status_queue.push_back(status_after(req.data));
			outstanding = status_queue.size();
		end
	end

endmodule

/* dv/dmx512_frame_receiver_test.sv */
`timescale 1ns / 1ps
module dmx512_frame_receiver_test;
	import dmxr_pkg::*;

	localparam int CHANNELS     = 512;
	localparam int TIMER_BITS   = 16;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int RANDOM_WORDS = 36;

	localparam op_t      OP_SPARE_5 = 3'd5;
	localparam op_t      OP_SPARE_6 = 3'd6;
	localparam op_t      OP_SPARE_7 = 3'd7;
	localparam reg_idx_t REG_SPARE  = 2'd3;

	typedef enum int {RX_STEADY, RX_COIN, RX_SKIP_ONE, RX_SPARSE} rx_pattern_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	reg_idx_t    cfg_index;
	cfg_data_t   cfg_data;
	int          fail_count;
	int          outstanding;
	int          cycles;
	int          words_sent;
	int          burst_left;
	int          gap_left;
	byte_t       cur_start;
	chan_t       cur_ready;
	rx_pattern_t rx_pattern;
	int          pattern_left;
	int          pattern_step;

	dmxr_req_if req_ch ();
	dmxr_rsp_if rsp_ch ();

	dmx512_frame_receiver #(
		.CHANNELS   (CHANNELS),
		.TIMER_BITS (TIMER_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dmx512_frame_receiver_checker #(
		.CHANNELS   (CHANNELS),
		.TIMER_BITS (TIMER_BITS)
	) status_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (pattern_left == 0) begin
			rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
			pattern_left = $urandom_range(16, 160);
		end
		pattern_left--;
		pattern_step++;
		case (rx_pattern)
			RX_STEADY:   rsp_ch.ready = 1'b1;
			RX_COIN:     rsp_ch.ready = 1'($urandom_range(0, 1));
			RX_SKIP_ONE: rsp_ch.ready = (pattern_step % 4) != 0;
			default:     rsp_ch.ready = (pattern_step % 8) < 2;
		endcase
	end

	task automatic send_word(op_t op, byte_t b, chan_t ch);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		while (gap_left > 0) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
			gap_left--;
		end
		req_ch.valid = 1'b1;
		req_ch.data  = {op, b, ch};
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic settle();
		req_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, cfg_data_t v);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = v;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic apply_settings(byte_t sc, tout_t to, chan_t rc);
		settle();
		write_reg(REG_START_CODE, {8'($urandom), sc});
		write_reg(REG_TIMEOUT, to);
		write_reg(REG_READY_CNT, {6'($urandom), rc});
		write_reg(REG_SPARE, 16'($urandom));
		cur_start = sc;
		cur_ready = rc;
	endtask

	task automatic frame_session();
		int    n;
		byte_t code;
		send_word(OP_BREAK, byte_t'($urandom), chan_t'($urandom));
		repeat ($urandom_range(0, 4)) send_word(OP_TICK, byte_t'($urandom), chan_t'($urandom));
		code = ($urandom_range(0, 6) == 0) ? byte_t'($urandom) : cur_start;
		send_word(OP_BYTE, code, chan_t'($urandom));
		n = $urandom_range(0, (cur_ready > 20) ? 24 : cur_ready + 4);
		for (int i = 0; i < n; i++) begin
			send_word(OP_BYTE, byte_t'($urandom), chan_t'($urandom));
			if ($urandom_range(0, 7) == 0)
				send_word(OP_TICK, byte_t'($urandom), chan_t'($urandom));
		end
		if ($urandom_range(0, 9) == 0)
			send_word(OP_BREAK, byte_t'($urandom), chan_t'($urandom));
		repeat ($urandom_range(0, 3)) send_word(OP_TICK, byte_t'($urandom), chan_t'($urandom));
		if ($urandom_range(0, 9) != 0)
			send_word(OP_COMMIT, byte_t'($urandom), chan_t'($urandom));
		repeat ($urandom_range(1, 3))
			send_word(OP_READ, byte_t'($urandom), ($urandom_range(0, 3) == 0) ?
				chan_t'($urandom) : chan_t'($urandom_range(0, n + 1)));
	endtask

	task automatic random_phase();
		int goal;
		goal = words_sent + RANDOM_WORDS;
		while (words_sent < goal) begin
			if ($urandom_range(0, 4) != 0)
				frame_session();
			else
				repeat ($urandom_range(1, 6))
					send_word(op_t'($urandom_range(0, 7)), byte_t'($urandom), chan_t'($urandom));
		end
	endtask

	task automatic full_frame(bit overrun);
		send_word(OP_BREAK, byte_t'($urandom), chan_t'($urandom));
		send_word(OP_BYTE, cur_start, chan_t'($urandom));
		repeat (CHANNELS) send_word(OP_BYTE, byte_t'($urandom), chan_t'($urandom));
		if (overrun) send_word(OP_BYTE, byte_t'($urandom), chan_t'($urandom));
		send_word(OP_COMMIT, byte_t'($urandom), chan_t'($urandom));
		send_word(OP_READ, byte_t'($urandom), 10'd1);
		send_word(OP_READ, byte_t'($urandom), 10'd512);
		send_word(OP_READ, byte_t'($urandom), 10'd513);
		send_word(OP_READ, byte_t'($urandom), 10'd0);
		send_word(OP_READ, byte_t'($urandom), chan_t'($urandom_range(1, CHANNELS)));
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		rsp_ch.ready  = 1'b0;
		cycles        = 0;
		words_sent    = 0;
		burst_left    = 0;
		gap_left      = 0;
		pattern_left  = 0;
		pattern_step  = 0;
		cur_start     = START_CODE_RST;
		cur_ready     = READY_CNT_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(OP_READ, 8'h00, 10'd0);
		send_word(OP_READ, 8'hFF, 10'd1);
		send_word(OP_READ, 8'h00, 10'd512);
		send_word(OP_READ, 8'h00, 10'd513);
		send_word(OP_READ, 8'h00, 10'd1023);
		send_word(OP_BYTE, 8'hFF, 10'd0);
		send_word(OP_SPARE_5, 8'h12, 10'd3);
		send_word(OP_SPARE_6, 8'hFF, 10'd1023);
		send_word(OP_SPARE_7, 8'h00, 10'd0);
		send_word(OP_BREAK, 8'h00, 10'd0);
		send_word(OP_BYTE, 8'h01, 10'd0);
		send_word(OP_BREAK, 8'h00, 10'd0);
		send_word(OP_BYTE, 8'h00, 10'd0);
		send_word(OP_BYTE, 8'hFF, 10'd0);
		send_word(OP_BYTE, 8'h00, 10'd0);
		send_word(OP_BYTE, 8'hA5, 10'd0);
		send_word(OP_TICK, 8'h00, 10'd0);
		send_word(OP_COMMIT, 8'h00, 10'd0);
		send_word(OP_READ, 8'h00, 10'd1);
		send_word(OP_READ, 8'h00, 10'd2);
		send_word(OP_READ, 8'h00, 10'd3);
		send_word(OP_READ, 8'h00, 10'd4);
		send_word(OP_BREAK, 8'h00, 10'd0);
		send_word(OP_TICK, 8'h00, 10'd0);

		random_phase();
		apply_settings(8'hFF, 16'd1, 10'd1);
		random_phase();
		apply_settings(8'h5A, 16'd0, 10'd0);
		random_phase();
		apply_settings(byte_t'($urandom), 16'd65535, 10'd512);
		random_phase();
		full_frame(1'b1);
		apply_settings(byte_t'($urandom), tout_t'($urandom_range(2, 10)),
			chan_t'($urandom_range(3, 12)));
		random_phase();

		req_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
